FILE: hdl/fxsm_pkg.sv
// ----------------------------------------------------------------------------
// fxsm_pkg: shared constants and types of the fixed-point sparsemax core
// Sizes, the reset value of the format register, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package fxsm_pkg;

  localparam int MaxLen  = 16;
  localparam int IdxW    = $clog2(MaxLen);
  localparam int CntW    = $clog2(MaxLen + 1);
  localparam int DataW   = 16;
  localparam int FracW   = 4;
  localparam int ProdW   = 2 * DataW;
  localparam int NumW    = 2 * DataW;
  localparam int DenW    = DataW + 1;
  localparam int DivCntW = $clog2(NumW + 1);

  localparam logic [FracW-1:0] FracReset = FracW'(10);

  // controller to datapath
  typedef struct packed {
    logic            load;
    logic            rank_wr;
    logic            scan_clr;
    logic            scan_mul;
    logic            scan_acc;
    logic            set_k;
    logic [CntW-1:0] k_val;
    logic            sorted_rd;
    logic            div_start;
    logic            emit;
    logic            clear_count;
    logic [CntW-1:0] idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            scan_fail;
    logic            div_done;
    logic            out_free;
  } stat_t;

endpackage

FILE: hdl/fxsm_if.sv
// ----------------------------------------------------------------------------
// fxsm_if: handshake channels of the sparsemax core
// Element input, result output and format register write channels.
// ----------------------------------------------------------------------------
interface fxsm_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [fxsm_pkg::DataW-1:0] element;
  logic                              final_element;
  modport source (output valid, output element, output final_element, input ready);
  modport sink   (input valid, input element, input final_element, output ready);
endinterface

interface fxsm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fxsm_pkg::DataW-1:0] projected;
  logic        [fxsm_pkg::IdxW-1:0]  position;
  logic                              last_result;
  modport source (output valid, output projected, output position, output last_result,
                  input ready);
  modport sink   (input valid, input projected, input position, input last_result,
                  output ready);
endinterface

interface fxsm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [fxsm_pkg::FracW-1:0] frac_bits;
  modport source (output valid, output frac_bits, input ready);
  modport sink   (input valid, input frac_bits, output ready);
endinterface

FILE: hdl/fxsm_div.sv
// ----------------------------------------------------------------------------
// fxsm_div: restoring divider of unsigned magnitudes
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module fxsm_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [fxsm_pkg::NumW-1:0] num_i,
  input  logic [fxsm_pkg::DenW-1:0] den_i,
  output logic                     done_o,
  output logic [fxsm_pkg::NumW-1:0] quo_o
);
  import fxsm_pkg::*;

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DenW-1:0]    rem_q, rem_d, den_q, den_d;
  logic [NumW-1:0]    quo_q, quo_d;
  logic [DenW:0]      shifted;
  logic [DenW:0]      trial;

  // shift in one dividend bit and try the subtract
  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      cnt_d = DivCntW'(NumW);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - DivCntW'(1);
      done_d = (cnt_q == DivCntW'(1));
      if (!trial[DenW]) begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/fxsm_dpath.sv
// ----------------------------------------------------------------------------
// fxsm_dpath: storage and arithmetic of the sparsemax core
// Element store, rank sort, support scan, threshold divide and the
// output register.
// ----------------------------------------------------------------------------
module fxsm_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fxsm_pkg::cmd_t             cmd_i,
  output fxsm_pkg::stat_t            stat_o,
  input  logic signed [fxsm_pkg::DataW-1:0] element_i,
  input  logic                       cfg_we_i,
  input  logic [fxsm_pkg::FracW-1:0] cfg_frac_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [fxsm_pkg::DataW-1:0] projected_o,
  output logic [fxsm_pkg::IdxW-1:0]  position_o,
  output logic                       last_result_o
);
  import fxsm_pkg::*;

  logic signed [DataW-1:0] val_q [MaxLen];
  logic [IdxW-1:0]         ord_q [MaxLen];
  logic [CntW-1:0]         count_q;
  logic [FracW-1:0]        frac_q;
  logic [DataW-1:0]        sum_q, sum_new_q;
  logic signed [ProdW-1:0] prod_q;
  logic [CntW-1:0]         k_q;
  logic [DataW-1:0]        tau_q;
  logic                    neg_q, bzero_q;
  logic                    out_valid_q;
  logic [DataW-1:0]        proj_q;
  logic [IdxW-1:0]         pos_q;
  logic                    last_q;

  logic [IdxW-1:0]         rd_addr;
  logic signed [DataW-1:0] rd_val;
  logic [MaxLen-1:0]       ahead;
  logic [IdxW-1:0]         rank;
  logic [DataW-1:0]        one;
  logic [CntW-1:0]         step_n;
  logic [DataW-1:0]        kf;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] mul_sh;
  logic [DataW-1:0]        coord;
  logic [DataW-1:0]        dvd;
  logic [DataW-1:0]        dvs;
  logic signed [NumW-1:0]  num_s;
  logic [NumW-1:0]         num_mag;
  logic signed [DenW-1:0]  den_s;
  logic [DenW-1:0]         den_mag;
  logic                    div_done;
  logic [NumW-1:0]         quo;
  logic [DataW-1:0]        diff;
  logic                    out_free;

  // read one element, in arrival or sorted order
  assign rd_addr = cmd_i.sorted_rd ? ord_q[cmd_i.idx[IdxW-1:0]] : cmd_i.idx[IdxW-1:0];
  assign rd_val  = val_q[rd_addr];

  // rank: elements that sort ahead of the one read
  always_comb begin
    for (int j = 0; j < MaxLen; j++) begin
      ahead[j] = (CntW'(j) < count_q) &&
                 ((val_q[j] > rd_val) || ((val_q[j] == rd_val) && (CntW'(j) < cmd_i.idx)));
    end
  end
  assign rank = IdxW'($countones(ahead));

  // support test terms
  assign one    = DataW'(1) << frac_q;
  assign step_n = cmd_i.idx + CntW'(1);
  assign kf     = DataW'(step_n) << frac_q;
  assign prod   = $signed(kf) * rd_val;
  assign mul_sh = prod_q >>> frac_q;
  assign coord  = one + mul_sh[DataW-1:0];

  // threshold operands as magnitudes
  assign dvd     = sum_q - one;
  assign dvs     = DataW'(k_q) << frac_q;
  assign num_s   = NumW'($signed(dvd)) <<< frac_q;
  assign num_mag = num_s[NumW-1] ? NumW'(-num_s) : NumW'(num_s);
  assign den_s   = DenW'($signed(dvs));
  assign den_mag = den_s[DenW-1] ? DenW'(-den_s) : DenW'(den_s);

  fxsm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_mag),
    .den_i   (den_mag),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign diff     = rd_val - tau_q;
  assign out_free = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      frac_q      <= FracReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frac_q <= cfg_frac_i;
      end
      if (cmd_i.clear_count) begin
        count_q <= '0;
      end else if (cmd_i.load && (count_q < CntW'(MaxLen))) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CntW'(MaxLen))) begin
      val_q[count_q[IdxW-1:0]] <= element_i;
    end
    if (cmd_i.rank_wr) begin
      ord_q[rank] <= cmd_i.idx[IdxW-1:0];
    end
    if (cmd_i.scan_clr) begin
      sum_q <= '0;
    end else if (cmd_i.scan_acc) begin
      sum_q <= sum_new_q;
    end
    if (cmd_i.scan_mul) begin
      prod_q    <= prod;
      sum_new_q <= sum_q + rd_val;
    end
    if (cmd_i.set_k) begin
      k_q <= cmd_i.k_val;
    end
    if (cmd_i.div_start) begin
      neg_q   <= num_s[NumW-1] ^ dvs[DataW-1];
      bzero_q <= (dvs == '0);
    end
    if (div_done) begin
      tau_q <= bzero_q ? '0 : (neg_q ? DataW'(-quo[DataW-1:0]) : quo[DataW-1:0]);
    end
    if (cmd_i.emit) begin
      proj_q <= diff[DataW-1] ? '0 : diff;
      pos_q  <= cmd_i.idx[IdxW-1:0];
      last_q <= (step_n == count_q);
    end
  end

  assign stat_o.count     = count_q;
  assign stat_o.scan_fail = ($signed(coord) <= $signed(sum_new_q));
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign projected_o   = proj_q;
  assign position_o    = pos_q;
  assign last_result_o = last_q;

endmodule

FILE: hdl/fxsm_ctrl.sv
// ----------------------------------------------------------------------------
// fxsm_ctrl: sequencer of the sparsemax core
// Steps load, rank sort, support scan, divide and emit over the datapath.
// ----------------------------------------------------------------------------
module fxsm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_final_i,
  output logic            in_ready_o,
  input  fxsm_pkg::stat_t stat_i,
  output fxsm_pkg::cmd_t  cmd_o
);
  import fxsm_pkg::*;

  typedef enum logic [2:0] {
    StLoad, StRank, StScanMul, StScanCmp, StDivStart, StDivWait, StEmit
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            idx_last;

  assign idx_last = ((idx_q + CntW'(1)) == stat_i.count);

  // next state and commands
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;
    case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_final_i) begin
          idx_d   = '0;
          state_d = StRank;
        end
      end
      StRank: begin
        cmd_o.rank_wr = 1'b1;
        if (idx_last) begin
          cmd_o.scan_clr = 1'b1;
          idx_d          = '0;
          state_d        = StScanMul;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      StScanMul: begin
        cmd_o.sorted_rd = 1'b1;
        cmd_o.scan_mul  = 1'b1;
        state_d         = StScanCmp;
      end
      StScanCmp: begin
        if (stat_i.scan_fail) begin
          cmd_o.set_k = 1'b1;
          cmd_o.k_val = idx_q;
          state_d     = StDivStart;
        end else begin
          cmd_o.scan_acc = 1'b1;
          if (idx_last) begin
            cmd_o.set_k = 1'b1;
            cmd_o.k_val = stat_i.count;
            state_d     = StDivStart;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = StScanMul;
          end
        end
      end
      StDivStart: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDivWait;
      end
      StDivWait: begin
        if (stat_i.div_done) begin
          idx_d   = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (idx_last) begin
            cmd_o.clear_count = 1'b1;
            state_d           = StLoad;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

FILE: hdl/fixed_point_sparsemax_core.sv
// ----------------------------------------------------------------------------
// fixed_point_sparsemax_core: streamed fixed-point sparsemax
// Top level joining the sequencer and the datapath to the channels.
// ----------------------------------------------------------------------------
// Elements load one beat per cycle; the beat flagged final_element closes
// the vector (up to 16 elements kept, the rest dropped). Processing then
// rank-sorts the elements, runs the support test over them in sorted
// order (multiply, then compare, per element; it stops at the first that
// fails), starts and runs the one-bit-a-cycle threshold divider, and
// sends one output beat per element at one per cycle while the sink is
// ready. Results come in arrival order with last_result on the final one;
// input is refused from the final beat until the last result is in the
// output register. frac_bits is written through the cfg channel, which
// is always ready, and resets to 10.
module fixed_point_sparsemax_core (
  input logic         clk_i,
  input logic         rst_ni,
  fxsm_in_if.sink     in_i,
  fxsm_out_if.source  out_o,
  fxsm_cfg_if.sink    cfg_i
);
  import fxsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  fxsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_final_i (in_i.final_element),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fxsm_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .element_i     (in_i.element),
    .cfg_we_i      (cfg_i.valid),
    .cfg_frac_i    (cfg_i.frac_bits),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .projected_o   (out_o.projected),
    .position_o    (out_o.position),
    .last_result_o (out_o.last_result)
  );

endmodule
